// ----- rtl/tcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Constants, item layout and per-stage arithmetic of the tilt compensated
// compass pipeline (square root, vectoring and rotation CORDIC steps).
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int IN_W         = 96;
    localparam int OUT_W        = 48;

    localparam int IPS        = 2;
    localparam int CS_STAGES  = (CORDIC_STEPS + IPS - 1) / IPS;
    localparam int SQ_ITERS   = 16;
    localparam int SQ_STAGES  = SQ_ITERS / IPS;

    localparam int VW       = 50;
    localparam int RW       = 34;
    localparam int ZW       = ANGLE_BITS + 2;
    localparam int KW       = 6;
    localparam int NORM_LOG = 44;

    localparam int OUT_RSH = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int OUT_RND = (ANGLE_BITS > 16) ? (1 << (ANGLE_BITS - 17)) : 0;
    localparam int OUT_LSH = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

    localparam logic signed [RW-1:0] GAIN_Q30 = RW'(32'h26DD3B6A);
    localparam logic signed [ZW-1:0] ROT_QUARTER = ZW'(1 << (ANGLE_BITS - 2));
    localparam logic signed [ZW-1:0] ROT_HALF    = ZW'(1 << (ANGLE_BITS - 1));
    localparam logic [ANGLE_BITS-1:0] ANG_HALF   = ANGLE_BITS'(1 << (ANGLE_BITS - 1));

    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // stage map
    localparam int ST_IN  = 0;
    localparam int ST_SUM = 1;
    localparam int ST_SQ0 = 2;
    localparam int ST_RE  = 2;
    localparam int ST_RS  = 3;
    localparam int ST_RI0 = 4;
    localparam int ST_PF  = ST_SQ0 + SQ_STAGES;
    localparam int ST_PE  = ST_PF + 1;
    localparam int ST_PS  = ST_PF + 2;
    localparam int ST_PI0 = ST_PF + 3;
    localparam int ST_TF  = ST_PI0 + CS_STAGES;
    localparam int ST_TI0 = ST_TF + 1;
    localparam int ST_TQ  = ST_TI0 + CS_STAGES;
    localparam int ST_M1  = ST_TQ + 1;
    localparam int ST_M2  = ST_TQ + 2;
    localparam int ST_M3  = ST_TQ + 3;
    localparam int ST_YF  = ST_TQ + 4;
    localparam int ST_YE  = ST_TQ + 5;
    localparam int ST_YS  = ST_TQ + 6;
    localparam int ST_YI0 = ST_TQ + 7;
    localparam int ST_OUT = ST_YI0 + CS_STAGES;
    localparam int NS     = ST_OUT + 1;

    typedef struct packed {
        logic signed [VW-1:0]   x;
        logic signed [VW-1:0]   y;
        logic [ANGLE_BITS-1:0]  z;
        logic                   zero;
        logic [KW-1:0]          k;
    } vec_t;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } rot_t;

    typedef struct packed {
        logic signed [15:0]    ax;
        logic signed [15:0]    ay;
        logic signed [15:0]    az;
        logic signed [15:0]    mx;
        logic signed [15:0]    my;
        logic signed [15:0]    mz;
        logic [31:0]           sqa;
        logic [31:0]           sqb;
        logic [31:0]           sq_n;
        logic [31:0]           sq_res;
        vec_t                  va;
        vec_t                  vb;
        logic [ANGLE_BITS-1:0] pitch_a;
        logic [ANGLE_BITS-1:0] roll_a;
        rot_t                  rp;
        rot_t                  rr;
        logic signed [15:0]    cp;
        logic signed [15:0]    sp;
        logic signed [15:0]    cr;
        logic signed [15:0]    sr;
        logic signed [31:0]    p_srsp;
        logic signed [31:0]    p_mzsr;
        logic signed [31:0]    p_mxcp;
        logic signed [31:0]    p_mzsp;
        logic signed [31:0]    p_mycr;
        logic signed [VW-1:0]  t1;
        logic signed [VW-1:0]  t2;
        logic signed [VW-1:0]  mycr14;
        logic signed [VW-1:0]  xh;
        logic signed [VW-1:0]  yh;
        logic [15:0]           pitch_o;
        logic [15:0]           roll_o;
        logic [15:0]           yaw_o;
    } item_t;

    function automatic logic [ANGLE_BITS-1:0] step_angle(input int i);
        logic [32:0] sum;
        sum = '0;
        if (i >= TAB_LEN)
        begin
            return '0;
        end
        sum = {1'b0, ATAN_TAB[i]} + (33'd1 << (31 - ANGLE_BITS));
        return ANGLE_BITS'(sum >> (32 - ANGLE_BITS));
    endfunction

    function automatic vec_t vec_fold(input logic signed [VW-1:0] y,
                                      input logic signed [VW-1:0] x);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.k    = '0;
        if (x < 0)
        begin
            v.x = -x;
            v.y = -y;
            v.z = ANG_HALF;
        end
        else
        begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

    function automatic vec_t vec_norm_k(input vec_t d);
        vec_t                 v;
        logic signed [VW-1:0] ay;
        logic signed [VW-1:0] m;
        int                   p;
        v  = d;
        ay = (d.y < 0) ? -d.y : d.y;
        m  = (d.x > ay) ? d.x : ay;
        p  = 0;
        for (int b = 0; b < VW; b++)
        begin
            if (m[b])
            begin
                p = b;
            end
        end
        v.k = (p < NORM_LOG) ? KW'(NORM_LOG - p) : '0;
        return v;
    endfunction

    function automatic vec_t vec_shift(input vec_t d);
        vec_t v;
        v   = d;
        v.x = d.x <<< d.k;
        v.y = d.y <<< d.k;
        return v;
    endfunction

    function automatic vec_t vec_iter(input vec_t d, input int i);
        vec_t                 v;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        v = d;
        if (i < CORDIC_STEPS && i < TAB_LEN)
        begin
            dx = d.y >>> i;
            dy = d.x >>> i;
            if (d.y > 0)
            begin
                v.x = d.x + dx;
                v.y = d.y - dy;
                v.z = d.z + step_angle(i);
            end
            else
            begin
                v.x = d.x - dx;
                v.y = d.y + dy;
                v.z = d.z - step_angle(i);
            end
        end
        return v;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] vec_angle(input vec_t v);
        return v.zero ? '0 : v.z;
    endfunction

    function automatic rot_t rot_fold(input logic [ANGLE_BITS-1:0] a);
        rot_t r;
        logic signed [ZW-1:0] z;
        z     = ZW'($signed(a));
        r.x   = GAIN_Q30;
        r.y   = '0;
        r.neg = 1'b0;
        r.z   = z;
        if (z > ROT_QUARTER)
        begin
            r.z   = z - ROT_HALF;
            r.neg = 1'b1;
        end
        else if (z < -ROT_QUARTER)
        begin
            r.z   = z + ROT_HALF;
            r.neg = 1'b1;
        end
        return r;
    endfunction

    function automatic rot_t rot_iter(input rot_t d, input int i);
        rot_t                 r;
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] dy;
        logic signed [ZW-1:0] sa;
        r = d;
        if (i < CORDIC_STEPS && i < TAB_LEN)
        begin
            dx = d.y >>> i;
            dy = d.x >>> i;
            sa = $signed({2'b00, step_angle(i)});
            if (d.z >= 0)
            begin
                r.x = d.x - dx;
                r.y = d.y + dy;
                r.z = d.z - sa;
            end
            else
            begin
                r.x = d.x + dx;
                r.y = d.y - dy;
                r.z = d.z + sa;
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [RW-1:0] v,
                                                  input logic neg);
        logic signed [RW-1:0] r;
        logic signed [15:0]   q;
        r = (v + RW'(32'sd32768)) >>> 16;
        if (r > RW'(32'sd16384))
        begin
            q = 16'sd16384;
        end
        else if (r < -RW'(32'sd16384))
        begin
            q = -16'sd16384;
        end
        else
        begin
            q = 16'(r);
        end
        return neg ? -q : q;
    endfunction

    function automatic logic [15:0] to_out16(input logic [ANGLE_BITS-1:0] a);
        logic signed [31:0] t;
        t = 32'($signed(a));
        t = (t + 32'(OUT_RND)) >>> OUT_RSH;
        t = t <<< OUT_LSH;
        return t[15:0];
    endfunction

    function automatic item_t sq_iter(input item_t d, input int j);
        item_t       q;
        logic [31:0] bitv;
        logic [31:0] trial;
        q     = d;
        bitv  = 32'd1 << (30 - 2 * j);
        trial = d.sq_res + bitv;
        if (d.sq_n >= trial)
        begin
            q.sq_n   = d.sq_n - trial;
            q.sq_res = (d.sq_res >> 1) + bitv;
        end
        else
        begin
            q.sq_res = d.sq_res >> 1;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tilt_compensated_compass.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_compensated_compass
// Pitch, roll and tilt compensated yaw from one accelerometer and one
// magnetometer sample per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one request: six raw 16-bit axis samples.
//   m_* channel returns pitch, roll and yaw as 16-bit binary angles
//   (32768 = pi).
//   Each request passes through an integer square root (two bits per stage),
//   three vectoring CORDICs and two rotation CORDICs (two iterations per
//   stage), plus the multiply stages for the rotated magnetic vector.
//   Throughput is one request per cycle unless the pipeline is full and the
//   receiver stalls; every stage carries its own valid.
//   When the receiver stalls, the result holds in the output stage and
//   upstream stages keep filling empty slots; s_tready falls only once the
//   path to the output is full.
//   Reset clears all valid bits; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module tilt_compensated_compass
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
    input  wire logic [tcc_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // pitch_angle, roll_angle, yaw_angle
    output logic [tcc_pkg::OUT_W-1:0]      m_tdata
);
    import tcc_pkg::*;

    item_t          pipe_reg  [NS];
    item_t          pipe_next [NS];
    logic [NS-1:0]  valid_reg;
    logic [NS-1:0]  stage_ce;

    function automatic item_t capture(input logic [IN_W-1:0] bus);
        item_t q;
        q     = '0;
        q.ax  = $signed(bus[15:0]);
        q.ay  = $signed(bus[31:16]);
        q.az  = $signed(bus[47:32]);
        q.mx  = $signed(bus[63:48]);
        q.my  = $signed(bus[79:64]);
        q.mz  = $signed(bus[95:80]);
        q.sqa = 32'($signed(bus[15:0]) * $signed(bus[15:0]));
        q.sqb = 32'($signed(bus[47:32]) * $signed(bus[47:32]));
        return q;
    endfunction

    function automatic item_t stage_step(input int st, input item_t d);
        item_t q;
        q = d;
        if (st == ST_SUM)
        begin
            q.sq_n   = d.sqa + d.sqb;
            q.sq_res = '0;
            q.va     = vec_fold(-VW'(d.ax), VW'(d.az));
        end
        if (st >= ST_SQ0 && st < ST_SQ0 + SQ_STAGES)
        begin
            for (int j = 0; j < IPS; j++)
            begin
                q = sq_iter(q, (st - ST_SQ0) * IPS + j);
            end
        end
        if (st == ST_RE)
        begin
            q.va = vec_norm_k(d.va);
        end
        if (st == ST_RS)
        begin
            q.va = vec_shift(d.va);
        end
        if (st >= ST_RI0 && st < ST_RI0 + CS_STAGES)
        begin
            for (int j = 0; j < IPS; j++)
            begin
                q.va = vec_iter(q.va, (st - ST_RI0) * IPS + j);
            end
        end
        if (st == ST_PF)
        begin
            q.vb = vec_fold(VW'(d.ay), VW'({1'b0, d.sq_res}));
        end
        if (st == ST_PE)
        begin
            q.vb = vec_norm_k(d.vb);
        end
        if (st == ST_PS)
        begin
            q.vb = vec_shift(d.vb);
        end
        if (st >= ST_PI0 && st < ST_PI0 + CS_STAGES)
        begin
            for (int j = 0; j < IPS; j++)
            begin
                q.vb = vec_iter(q.vb, (st - ST_PI0) * IPS + j);
            end
        end
        if (st == ST_TF)
        begin
            q.pitch_a = vec_angle(d.vb);
            q.roll_a  = vec_angle(d.va);
            q.rp      = rot_fold(vec_angle(d.vb));
            q.rr      = rot_fold(vec_angle(d.va));
        end
        if (st >= ST_TI0 && st < ST_TI0 + CS_STAGES)
        begin
            for (int j = 0; j < IPS; j++)
            begin
                q.rp = rot_iter(q.rp, (st - ST_TI0) * IPS + j);
                q.rr = rot_iter(q.rr, (st - ST_TI0) * IPS + j);
            end
        end
        if (st == ST_TQ)
        begin
            q.cp = to_q14(d.rp.x, d.rp.neg);
            q.sp = to_q14(d.rp.y, d.rp.neg);
            q.cr = to_q14(d.rr.x, d.rr.neg);
            q.sr = to_q14(d.rr.y, d.rr.neg);
        end
        if (st == ST_M1)
        begin
            q.p_srsp = 32'(d.sr * d.sp);
            q.p_mzsr = 32'(d.mz * d.sr);
            q.p_mxcp = 32'(d.mx * d.cp);
            q.p_mzsp = 32'(d.mz * d.sp);
            q.p_mycr = 32'(d.my * d.cr);
        end
        if (st == ST_M2)
        begin
            q.t1     = VW'(d.mx * d.p_srsp);
            q.t2     = VW'(d.p_mzsr * d.cp);
            q.xh     = (VW'(d.p_mxcp) + VW'(d.p_mzsp)) <<< 14;
            q.mycr14 = VW'(d.p_mycr) <<< 14;
        end
        if (st == ST_M3)
        begin
            q.yh = d.t1 + d.mycr14 - d.t2;
        end
        if (st == ST_YF)
        begin
            q.vb = vec_fold(d.yh, d.xh);
        end
        if (st == ST_YE)
        begin
            q.vb = vec_norm_k(d.vb);
        end
        if (st == ST_YS)
        begin
            q.vb = vec_shift(d.vb);
        end
        if (st >= ST_YI0 && st < ST_YI0 + CS_STAGES)
        begin
            for (int j = 0; j < IPS; j++)
            begin
                q.vb = vec_iter(q.vb, (st - ST_YI0) * IPS + j);
            end
        end
        if (st == ST_OUT)
        begin
            q.pitch_o = to_out16(d.pitch_a);
            q.roll_o  = to_out16(d.roll_a);
            q.yaw_o   = to_out16(vec_angle(d.vb));
        end
        return q;
    endfunction

    always_comb
    begin
        stage_ce[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_ce[k] = !valid_reg[k] || stage_ce[k+1];
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            always_comb
            begin
                pipe_next[g] = capture(s_tdata);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (stage_ce[g])
                begin
                    valid_reg[g] <= s_tvalid;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                pipe_next[g] = stage_step(g, pipe_reg[g-1]);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (stage_ce[g])
                begin
                    valid_reg[g] <= valid_reg[g-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ce[g])
            begin
                pipe_reg[g] <= pipe_next[g];
            end
        end
    end

    assign s_tready = stage_ce[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {pipe_reg[NS-1].yaw_o, pipe_reg[NS-1].roll_o,
                       pipe_reg[NS-1].pitch_o};

    // full pipeline under backpressure takes no new request
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !m_tready |-> !s_tready)
        else $error("request taken while pipeline full and stalled");

    // accepted request occupies the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted request not held in first stage");

    // drained output with empty predecessor goes idle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !valid_reg[NS-2] |=> !m_tvalid)
        else $error("result repeated after delivery");

endmodule
`default_nettype wire
